/* src/tgs_pkg.sv */
package tgs_pkg;

   localparam int MaxRows  = 64;
   localparam int RowW     = $clog2(MaxRows);
   localparam int CntW     = RowW + 1;
   localparam int DataW    = 32;
   localparam int NumW     = 47;
   localparam int DivW     = 63;

   localparam logic [15:0] MaxSweepsRst = 16'd1000;
   localparam logic [15:0] TolRst       = 16'd66;

   // configuration register indexes
   localparam logic [0:0] RegMaxSweeps = 1'b0;
   localparam logic [0:0] RegTolerance = 1'b1;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_RD,
      ST_WAIT,
      ST_MUL_LO,
      ST_MUL_UP,
      ST_DIV,
      ST_DIVW,
      ST_ERR,
      ST_ERRW,
      ST_NEXT,
      ST_OUT_RD,
      ST_OUT_WAIT,
      ST_OUT
   } state_type;

   // divider request/status between the sequencer and the shared divider
   typedef struct packed {
      logic            start;
      logic [DivW-1:0] dividend;
      logic [DataW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic            busy;
      logic [DivW-1:0] quotient;
   } div_rsp_type;

endpackage

/* src/tridiagonal_gauss_seidel_solver.sv */
// Tridiagonal Gauss-Seidel solver in signed Q16.16. Rows are loaded one per
// cycle (up to 64; extra rows are dropped); the row with tlast set starts the
// solve, during which req_tready is low. Each row update makes two passes of
// one shared 32x32 multiplier, then two passes of one shared restoring
// divider that yields one quotient bit per cycle, one for the new value and
// one for the relative change (a pass is skipped when the diagonal or the
// new value is zero). When the solve ends, one transaction per row is sent
// on the rsp side (row_index, solution, final_entry, cap_reached); rows go
// out one at a time, each read from the row store before it is offered.
module tridiagonal_gauss_seidel_solver (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: sub_coef, diag_coef, super_coef, rhs_value, start_guess
   input  logic [159:0] req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: row_index[5:0], solution[37:6], zero fill
   output logic [39:0]  rsp_tdata,
   output logic         rsp_tlast,
   // tuser: cap_reached
   output logic         rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [0:0]   csr_index,
   input  logic [15:0]  csr_data
);
   import tgs_pkg::*;

   state_type state_ff, state_in;

   logic [15:0]     max_sweeps_ff, tolerance_ff;
   logic [CntW-1:0] rows_ff, rows_in;
   logic [RowW-1:0] idx_ff, idx_in;
   logic [15:0]     sweep_ff, sweep_in;
   logic [15:0]     maxerr_ff, maxerr_in;
   logic            cap_ff, cap_in;
   logic signed [NumW+1:0] num_ff, num_in;
   logic signed [DataW-1:0] newv_ff, newv_in;
   logic signed [DataW-1:0] xprev_ff, xprev_in;
   logic signed [63:0] prod_ff;
   logic signed [DataW-1:0] mul_a, mul_b;
   logic            mul_en;

   // row stores
   logic            wr_en;
   logic [RowW-1:0] wr_addr, rd_next;
   logic [DataW-1:0] lo_q, dg_q, up_q, rh_q, es_q, es_nq, es_wd;
   logic            in_acc, out_acc, load_wr;

   assign in_acc  = req_tvalid && req_tready;
   assign out_acc = rsp_tvalid && rsp_tready;
   assign load_wr = in_acc && (rows_ff < CntW'(MaxRows));
   assign wr_en   = load_wr || (state_ff == ST_NEXT);
   assign wr_addr = load_wr ? rows_ff[RowW-1:0] : idx_ff;
   assign es_wd   = load_wr ? req_tdata[159:128] : newv_ff;
   assign rd_next = idx_ff + RowW'(1);

   tgs_ram #(.Width(DataW), .Depth(MaxRows)) u_lo (.clock, .wr_en(load_wr),
      .wr_addr, .wr_data(req_tdata[31:0]), .rd_addr(idx_ff), .rd_data(lo_q));
   tgs_ram #(.Width(DataW), .Depth(MaxRows)) u_dg (.clock, .wr_en(load_wr),
      .wr_addr, .wr_data(req_tdata[63:32]), .rd_addr(idx_ff), .rd_data(dg_q));
   tgs_ram #(.Width(DataW), .Depth(MaxRows)) u_up (.clock, .wr_en(load_wr),
      .wr_addr, .wr_data(req_tdata[95:64]), .rd_addr(idx_ff), .rd_data(up_q));
   tgs_ram #(.Width(DataW), .Depth(MaxRows)) u_rh (.clock, .wr_en(load_wr),
      .wr_addr, .wr_data(req_tdata[127:96]), .rd_addr(idx_ff), .rd_data(rh_q));
   tgs_ram #(.Width(DataW), .Depth(MaxRows)) u_es (.clock, .wr_en,
      .wr_addr, .wr_data(es_wd), .rd_addr(idx_ff), .rd_data(es_q));
   tgs_ram #(.Width(DataW), .Depth(MaxRows)) u_esn (.clock, .wr_en,
      .wr_addr, .wr_data(es_wd), .rd_addr(rd_next), .rd_data(es_nq));

   // shared divider
   div_req_type dreq;
   div_rsp_type drsp;
   tgs_div u_div (.clock, .reset, .req(dreq), .rsp(drsp));

   // shared multiplier with registered product: lower term in ST_WAIT,
   // upper term in ST_MUL_LO
   always_comb begin
      mul_en = (state_ff == ST_WAIT) || (state_ff == ST_MUL_LO);
      mul_a  = (state_ff == ST_WAIT) ? $signed(lo_q) : $signed(up_q);
      mul_b  = (state_ff == ST_WAIT) ? xprev_ff : $signed(es_nq);
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= 64'(mul_a) * 64'(mul_b);
      end
   end

   // truncate toward zero by 2^16
   function automatic logic signed [NumW+1:0] qtrunc(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = (p < 0) ? (p + 64'sd65535) >>> 16 : p >>> 16;
      return (NumW+2)'(t);
   endfunction

   logic signed [NumW+1:0] num_sat;
   logic [DataW-1:0] nmag, dmag, qsat;
   logic [DataW:0]   diffabs;
   logic             is_first, is_last, qneg;
   logic [DataW:0]   q33;
   logic [15:0]      row_err, err_new;
   logic             again;

   always_comb begin
      is_first = (idx_ff == '0);
      is_last  = ({1'b0, idx_ff} == rows_ff - CntW'(1));
      if (num_ff > (NumW+2)'(64'sd70368744177663)) num_sat = (NumW+2)'(64'sd70368744177663);
      else if (num_ff < -(NumW+2)'(64'sd70368744177664))
         num_sat = -(NumW+2)'(64'sd70368744177664);
      else num_sat = num_ff;
      qneg = num_sat[NumW+1] ^ dg_q[DataW-1];
      dmag = dg_q[DataW-1] ? DataW'(-$signed(dg_q)) : dg_q;
      nmag = newv_ff[DataW-1] ? DataW'(-newv_ff) : newv_ff;
      diffabs = ($signed({es_q[DataW-1], es_q}) >= $signed({newv_ff[DataW-1], newv_ff}))
         ? {es_q[DataW-1], es_q} - {newv_ff[DataW-1], newv_ff}
         : {newv_ff[DataW-1], newv_ff} - {es_q[DataW-1], es_q};
      q33 = (drsp.quotient[DivW-1:DataW] != '0) ? {1'b1, 32'h0} : {1'b0, drsp.quotient[DataW-1:0]};
      if (!qneg) qsat = (q33 > 33'h7fffffff) ? 32'h7fffffff : q33[DataW-1:0];
      else qsat = (q33 > 33'h80000000) ? 32'h80000000 : DataW'(-q33[DataW-1:0]);
      // relative change of this row, zero new value counts as maximal
      if (newv_ff == '0) row_err = 16'hffff;
      else if (drsp.quotient[DivW-1:16] != '0) row_err = 16'hffff;
      else row_err = drsp.quotient[15:0];
      err_new = (row_err > maxerr_ff) ? row_err : maxerr_ff;
      again   = (err_new > tolerance_ff) && ((sweep_ff + 16'd1) < max_sweeps_ff);
   end

   // divider requests
   always_comb begin
      dreq = '0;
      if (state_ff == ST_DIV && dg_q != '0) begin
         dreq.start    = 1'b1;
         dreq.dividend = DivW'(num_sat[NumW+1] ? -num_sat : num_sat) << 16;
         dreq.divisor  = dmag;
      end else if (state_ff == ST_ERR && newv_ff != '0) begin
         dreq.start    = 1'b1;
         dreq.dividend = DivW'(diffabs) << 16;
         dreq.divisor  = nmag;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD:     if (in_acc && req_tlast) state_in = ST_RD;
         ST_RD:       state_in = ST_WAIT;
         ST_WAIT:     state_in = ST_MUL_LO;
         ST_MUL_LO:   state_in = ST_MUL_UP;
         ST_MUL_UP:   state_in = ST_DIV;
         ST_DIV:      state_in = (dg_q != '0) ? ST_DIVW : ST_ERR;
         ST_DIVW:     if (!drsp.busy) state_in = ST_ERR;
         ST_ERR:      state_in = (newv_ff != '0) ? ST_ERRW : ST_NEXT;
         ST_ERRW:     if (!drsp.busy) state_in = ST_NEXT;
         ST_NEXT: begin
            if (!is_last || again) state_in = ST_RD;
            else state_in = ST_OUT_RD;
         end
         ST_OUT_RD:   state_in = ST_OUT_WAIT;
         ST_OUT_WAIT: state_in = ST_OUT;
         ST_OUT:      if (out_acc) state_in = is_last ? ST_LOAD : ST_OUT_RD;
         default:     state_in = ST_LOAD;
      endcase
   end

   // datapath updates
   always_comb begin
      rows_in   = rows_ff;
      idx_in    = idx_ff;
      sweep_in  = sweep_ff;
      maxerr_in = maxerr_ff;
      cap_in    = cap_ff;
      num_in    = num_ff;
      newv_in   = newv_ff;
      xprev_in  = xprev_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (load_wr) rows_in = rows_ff + CntW'(1);
            idx_in    = '0;
            sweep_in  = 16'd1;
            maxerr_in = '0;
         end
         ST_WAIT:   num_in = (NumW+2)'($signed(rh_q));
         ST_MUL_LO: if (!is_first) num_in = num_ff - qtrunc(prod_ff);
         ST_MUL_UP: if (!is_last) num_in = num_ff - qtrunc(prod_ff);
         ST_DIV: begin
            if (dg_q == '0) begin
               if (num_sat > 0) newv_in = 32'sh7fffffff;
               else if (num_sat < 0) newv_in = 32'sh80000000;
               else newv_in = '0;
            end
         end
         ST_DIVW: if (!drsp.busy) newv_in = $signed(qsat);
         ST_NEXT: begin
            maxerr_in = err_new;
            xprev_in  = newv_ff;
            idx_in    = idx_ff + RowW'(1);
            if (is_last) begin
               idx_in   = '0;
               sweep_in = sweep_ff + 16'd1;
               cap_in   = (sweep_ff + 16'd1) == max_sweeps_ff;
               if (again) maxerr_in = '0;
            end
         end
         ST_OUT: if (out_acc) begin
            idx_in = idx_ff + RowW'(1);
            if (is_last) rows_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         rows_ff       <= '0;
         idx_ff        <= '0;
         sweep_ff      <= 16'd1;
         maxerr_ff     <= '0;
         cap_ff        <= 1'b0;
         max_sweeps_ff <= MaxSweepsRst;
         tolerance_ff  <= TolRst;
      end else begin
         state_ff  <= state_in;
         rows_ff   <= rows_in;
         idx_ff    <= idx_in;
         sweep_ff  <= sweep_in;
         maxerr_ff <= maxerr_in;
         cap_ff    <= cap_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               RegMaxSweeps: max_sweeps_ff <= csr_data;
               RegTolerance: tolerance_ff  <= csr_data;
               default: ;
            endcase
         end
      end
      num_ff   <= (state_ff == ST_DIV) ? num_sat : num_in;
      newv_ff  <= newv_in;
      xprev_ff <= xprev_in;
   end

   // outputs
   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {2'b00, es_q, idx_ff};
   assign rsp_tlast  = is_last;
   assign rsp_tuser  = cap_ff;

   // assertions
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("input and output both open");
   a_rows_bound: assert property (@(posedge clock) disable iff (reset)
      rows_ff <= CntW'(MaxRows)) else $error("row count overflow");
   a_clear_after: assert property (@(posedge clock) disable iff (reset)
      out_acc && rsp_tlast |=> rows_ff == '0) else $error("rows not cleared");
endmodule

/* src/tgs_ram.sv */
module tgs_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* src/tgs_div.sv */
module tgs_div (
   input  logic                    clock,
   input  logic                    reset,
   input  tgs_pkg::div_req_type    req,
   output tgs_pkg::div_rsp_type    rsp
);
   import tgs_pkg::*;

   // restoring unsigned divider, one quotient bit a cycle
   logic [DivW-1:0]  quo_ff, quo_in;
   logic [DataW:0]   rem_ff, rem_in;
   logic [DataW-1:0] dvs_ff, dvs_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DataW+1:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, quo_ff[DivW-1]} - {2'b00, dvs_ff};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
         cnt_in  = 6'(DivW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DataW+1]) begin
            rem_in = trial[DataW:0];
            quo_in = {quo_ff[DivW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DataW-1:0], quo_ff[DivW-1]};
            quo_in = {quo_ff[DivW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.quotient = quo_ff;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
   import tgs_pkg::*;

   // scoreboard: row stores, sweep prediction and expected solution queue
   typedef struct {
      logic [5:0]  row;
      logic [31:0] sol;
      logic        fin;
      logic        cap;
   } sol_entry_type;

   class solve_scoreboard;
      int            lo_st[MaxRows];
      int            dg_st[MaxRows];
      int            up_st[MaxRows];
      int            rhs_st[MaxRows];
      int            est_st[MaxRows];
      int            n_rows;
      logic [15:0]   sweeps_cap;
      logic [15:0]   tol;
      int            errors;
      sol_entry_type sol_q[$];

      function new();
         n_rows     = 0;
         sweeps_cap = MaxSweepsRst;
         tol        = TolRst;
         errors     = 0;
      endfunction

      function void set_reg(logic [0:0] idx, logic [15:0] val);
         if (idx == RegMaxSweeps) sweeps_cap = val;
         else tol = val;
      endfunction

      function int row_value(int i, int n);
         longint num;
         longint q;
         num = rhs_st[i];
         if (i > 0) num -= (longint'(lo_st[i]) * longint'(est_st[i-1])) / 65536;
         if (i + 1 < n) num -= (longint'(up_st[i]) * longint'(est_st[i+1])) / 65536;
         if (num > 64'sd70368744177663) num = 64'sd70368744177663;
         if (num < -64'sd70368744177664) num = -64'sd70368744177664;
         // zero diagonal saturates by sign of numerator
         if (dg_st[i] == 0) begin
            if (num > 0) return 32'h7fffffff;
            if (num < 0) return 32'h80000000;
            return 0;
         end
         q = (num * 65536) / longint'(dg_st[i]);
         if (q > 64'sd2147483647) return 32'h7fffffff;
         if (q < -64'sd2147483648) return 32'h80000000;
         return int'(q);
      endfunction

      function int rel_err(int old_v, int new_v);
         longint diff;
         longint mag;
         longint q;
         diff = longint'(old_v) - longint'(new_v);
         if (diff < 0) diff = -diff;
         mag = (new_v < 0) ? -longint'(new_v) : longint'(new_v);
         if (mag == 0) return 65535;
         q = (diff * 65536) / mag;
         return (q > 65535) ? 65535 : int'(q);
      endfunction

      function void note_row(int sub, int dia, int sup, int rhs, int guess, bit last);
         logic [15:0]   cnt;
         int            max_e;
         int            nv;
         int            e;
         sol_entry_type ent;
         if (n_rows < MaxRows) begin
            lo_st[n_rows]  = sub;
            dg_st[n_rows]  = dia;
            up_st[n_rows]  = sup;
            rhs_st[n_rows] = rhs;
            est_st[n_rows] = guess;
            n_rows++;
         end
         if (!last) return;
         cnt = 16'd1;
         forever begin
            max_e = 0;
            for (int i = 0; i < n_rows; i++) begin
               nv = row_value(i, n_rows);
               e  = rel_err(est_st[i], nv);
               est_st[i] = nv;
               if (e > max_e) max_e = e;
            end
            cnt = cnt + 16'd1;
            if (!(max_e > tol && cnt < sweeps_cap)) break;
         end
         for (int k = 0; k < n_rows; k++) begin
            ent.row = k[5:0];
            ent.sol = est_st[k];
            ent.fin = (k + 1 == n_rows);
            ent.cap = (cnt == sweeps_cap);
            sol_q.push_back(ent);
         end
         n_rows = 0;
      endfunction

      function void check_sol(logic [5:0] row, logic [31:0] sol, logic fin, logic cap);
         sol_entry_type ex;
         if (sol_q.size() == 0) begin
            $display("%0t: unexpected result row %0d sol %h", $realtime, row, sol);
            errors++;
            return;
         end
         ex = sol_q.pop_front();
         if (row !== ex.row) begin
            $display("%0t: row_index expected %0d actual %0d", $realtime, ex.row, row);
            errors++;
         end
         if (sol !== ex.sol) begin
            $display("%0t: solution expected %h actual %h", $realtime, ex.sol, sol);
            errors++;
         end
         if (fin !== ex.fin) begin
            $display("%0t: final_entry expected %b actual %b", $realtime, ex.fin, fin);
            errors++;
         end
         if (cap !== ex.cap) begin
            $display("%0t: cap_reached expected %b actual %b", $realtime, ex.cap, cap);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [39:0]  rsp_tdata;
   logic         rsp_tlast;
   logic         rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [0:0]   csr_index = '0;
   logic [15:0]  csr_data = '0;

   solve_scoreboard sb = new();
   bit  quiet    = 0;
   bit  hold_rsp = 0;
   int  rows_sent = 0;

   tridiagonal_gauss_seidel_solver dut (.*);

   always #5 clock = ~clock;

   // run limit
   initial begin
      #60ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // receiver: check results, random stalls and one long hold-off
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_sol(rsp_tdata[5:0], rsp_tdata[37:6], rsp_tlast, rsp_tuser);
         // long hold-off starts once the block offers a result
         if (hold_rsp && rsp_tvalid) begin
            hold_rsp   = 0;
            stall_left = 400;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic write_reg(logic [0:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, val);
      csr_valid <= 1'b0;
   endtask

   // wait until all solutions are out, then let the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.sol_q.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic send_row(int sub, int dia, int sup, int rhs, int guess, bit last);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {guess, rhs, sup, dia, sub};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_row(sub, dia, sup, rhs, guess, last);
      rows_sent++;
   endtask

   // one system of n rows; dominant systems converge, others are raw bits
   task automatic send_system(int n, bit dominant);
      int sub, dia, sup, rhs, guess;
      for (int i = 0; i < n; i++) begin
         if (dominant) begin
            dia = ($urandom_range(4, 20) << 16) + $urandom_range(0, 65535);
            if ($urandom_range(0, 1)) dia = -dia;
            sub = $urandom_range(0, 131071) - 65536;
            sup = $urandom_range(0, 131071) - 65536;
            rhs = $urandom_range(0, 32'h01ffffff) - 32'h01000000;
            guess = $urandom;
            if ($urandom_range(0, 3) == 0) guess = guess >>> 12;
         end else begin
            sub = $urandom; dia = $urandom; sup = $urandom;
            rhs = $urandom; guess = $urandom;
         end
         send_row(sub, dia, sup, rhs, guess, i == n - 1);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: single rows, one sweep pair each
      send_row(0, 32'h00020000, 0, 32'h00050000, 0, 1);
      send_row(32'h7fffffff, 32'hfffe8000, 32'h80000000, 32'h80000000, 32'h7fffffff, 1);
      drain();

      // cap of two, zero tolerance: extremes and zero diagonal cases
      write_reg(RegMaxSweeps, 16'd2);
      write_reg(RegTolerance, 16'd0);
      send_row(0, 0, 0, 32'h00010000, 0, 1);
      send_row(0, 0, 0, 32'hffff0000, 0, 1);
      send_row(0, 0, 0, 0, 0, 1);
      for (int i = 0; i < 3; i++)
         send_row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, i == 2);
      for (int i = 0; i < 3; i++)
         send_row(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, i == 2);
      for (int i = 0; i < 3; i++)
         send_row(32'h80000000, 32'h00000001, 32'h7fffffff, 32'h7fffffff, 32'h80000000, i == 2);
      send_row(0, 32'h00010000, 0, 0, 32'h00010000, 1);
      drain();

      // caps below two: one sweep only
      write_reg(RegMaxSweeps, 16'd1);
      send_system(2, 1);
      drain();
      write_reg(RegMaxSweeps, 16'd0);
      write_reg(RegTolerance, 16'd65535);
      send_system(3, 0);
      drain();

      // random part; the store overflow system and a long output hold-off
      write_reg(RegMaxSweeps, 16'd2);
      hold_rsp = 1;
      send_system(66, 0);
      send_system(3, 1);
      drain();
      while (rows_sent < 330) begin
         logic [15:0] t;
         case ($urandom_range(0, 3))
            0: t = 16'd0;
            1: t = 16'd65535;
            default: t = 16'($urandom_range(0, 2000));
         endcase
         write_reg(RegMaxSweeps, 16'($urandom_range(2, 12)));
         write_reg(RegTolerance, t);
         for (int s = 0; s < 8; s++)
            send_system($urandom_range(1, 6), $urandom_range(0, 9) < 7);
         drain();
      end

      // largest cap, no idling: single rows converge after two sweeps
      quiet = 1;
      write_reg(RegMaxSweeps, 16'd65535);
      write_reg(RegTolerance, 16'd0);
      for (int i = 0; i < 20; i++)
         send_row($urandom, ($urandom_range(1, 255) << 16), $urandom,
                  ($urandom_range(256, 65535) << 8) | 32'h100, $urandom, 1);
      drain();

      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* sim.f */
src/tgs_pkg.sv
src/tgs_ram.sv
src/tgs_div.sv
src/tridiagonal_gauss_seidel_solver.sv
sim/tb.sv
